/* sv/grid_ray_cast_top_defines.svh */
// Assertion macros for the grid ray cast block.
// Included by the modules that carry concurrent checks; relies on clk and rst in scope.
`ifndef GRID_RAY_CAST_TOP_DEFINES_SVH
`define GRID_RAY_CAST_TOP_DEFINES_SVH

// same-cycle implication
`define GRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/grc_pkg.sv */
// Shared constants for the grid ray cast block: field widths, codes, defaults.
// No dependencies.
package grc_pkg;

  localparam int GRID_SIDE_DEFAULT  = 256;
  localparam int COORD_BITS_DEFAULT = 11;

  localparam int CFG_W       = 9;
  localparam int CFG_INDEX_W = 1;
  localparam int CELL_ADDR_W = 16;
  localparam int DIST_W      = 16;
  localparam int FRAC_BITS   = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CAST = 1'b1;

  localparam logic [CFG_W-1:0] GRID_DIM_RESET = 9'd256;

endpackage

/* sv/grid_ray_cast_top.sv */
// Grid ray cast: a load word is written into the occupancy store as it is taken. A cast posts its
// result word after it walks N cells (one occupancy RAM read per cell, one cell per cycle), then
// a bit-serial square root of COORD_BITS + 5 steps. One item at a time: a cast holds off the
// input until its result word is posted, longer while a result waits in the output.
// Reset (rst, synchronous) clears control and sets width and height to 256; the occupancy
// store is not cleared. Needs grc_pkg, grc_ram, the defines header; GRID_SIDE a power of two.
`include "grid_ray_cast_top_defines.svh"

module grid_ray_cast_top #(
  parameter int GRID_SIDE  = grc_pkg::GRID_SIDE_DEFAULT,
  parameter int COORD_BITS = grc_pkg::COORD_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [grc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [grc_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  logic                            func,
  input  logic [grc_pkg::CELL_ADDR_W-1:0] cell_address,
  input  logic                            cell_blocked,
  input  logic signed [COORD_BITS-1:0]    start_col,
  input  logic signed [COORD_BITS-1:0]    start_row,
  input  logic signed [COORD_BITS-1:0]    end_col,
  input  logic signed [COORD_BITS-1:0]    end_row,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic                            blocked,
  output logic [grc_pkg::DIST_W-1:0]      hit_distance
);

  localparam int C      = COORD_BITS;
  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ERR_W  = C + 3;
  localparam int ROOT_W = C + 1 + grc_pkg::FRAC_BITS;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int CNT_W  = $clog2(ROOT_W + 1);
  localparam int CMP_W  = (C > grc_pkg::CFG_W) ? C : grc_pkg::CFG_W;
  localparam int PROD_W = 2 * grc_pkg::CFG_W + 1;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SETUP  = 7'b0000010,
    ST_WALK   = 7'b0000100,
    ST_SQUARE = 7'b0001000,
    ST_SUM    = 7'b0010000,
    ST_DONE   = 7'b0100000,
    ST_ROOT   = 7'b1000000
  } state_t;

  state_t state;

  logic [grc_pkg::CFG_W-1:0] grid_width;
  logic [grc_pkg::CFG_W-1:0] grid_height;

  logic signed [C-1:0] c0, r0, c1, r1;
  logic signed [C-1:0] a, b, a1;
  logic                steep, a_up, b_up;
  logic [C-1:0]        da, db;
  logic signed [ERR_W-1:0] err;
  logic                issue_live;

  logic                chk_valid, chk_out, chk_last;
  logic signed [C-1:0] chk_col, chk_row;

  logic                stop_blocked;
  logic signed [C:0]   diff_c, diff_r;
  logic [2*C-1:0]      sq_c, sq_r;
  logic [RAD_W-1:0]    rad;
  logic [REM_W-1:0]    rem;
  logic [ROOT_W-1:0]   root;
  logic [CNT_W-1:0]    cnt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic                ram_rdata;

  // setup terms
  logic signed [C:0] dcol, drow, acol_w, arow_w;
  logic [C-1:0]      acol, arow;
  logic              steep_s;

  // walk terms
  logic signed [C-1:0]       cur_col, cur_row, a_next, b_next;
  logic signed [ERR_W-1:0]   err_inc, err_next, db_ext, da_ext;
  logic                      step_b, cur_last, cur_out, chk_stop;
  logic [grc_pkg::CFG_W-1:0] col9, row9;
  logic [PROD_W-1:0]         lin;

  // distance terms
  logic signed [C:0] mag_c_w, mag_r_w;
  logic [C-1:0]      mag_c, mag_r;
  logic [2*C:0]      sum_sq;
  logic [REM_W-1:0]  rem_sh, trial;

  logic cmd_acc;
  logic res_post;

  assign cfg_ready = 1'b1;
  assign cmd_ready = (state == ST_IDLE);
  assign cmd_acc   = cmd_valid && cmd_ready;
  assign res_post  = (state == ST_DONE) && (!res_valid || res_ready);

  always_comb begin
    dcol   = {c1[C-1], c1} - {c0[C-1], c0};
    drow   = {r1[C-1], r1} - {r0[C-1], r0};
    acol_w = dcol[C] ? -dcol : dcol;
    arow_w = drow[C] ? -drow : drow;
    acol   = acol_w[C-1:0];
    arow   = arow_w[C-1:0];
    steep_s = acol < arow;
  end

  always_comb begin
    cur_col  = steep ? b : a;
    cur_row  = steep ? a : b;
    cur_last = (a == a1);
    a_next   = a_up ? a + 1'b1 : a - 1'b1;
    b_next   = b_up ? b + 1'b1 : b - 1'b1;
    db_ext   = $signed({{(ERR_W - C){1'b0}}, db});
    da_ext   = $signed({{(ERR_W - C){1'b0}}, da});
    err_inc  = err + db_ext;
    step_b   = $signed({err_inc, 1'b0}) >= $signed({1'b0, da_ext});
    err_next = step_b ? err_inc - da_ext : err_inc;
    cur_out  = cur_col[C-1] || cur_row[C-1]
            || (CMP_W'($unsigned(cur_col)) >= CMP_W'(grid_width))
            || (CMP_W'($unsigned(cur_row)) >= CMP_W'(grid_height));
    col9     = grc_pkg::CFG_W'($unsigned(cur_col));
    row9     = grc_pkg::CFG_W'($unsigned(cur_row));
    lin      = PROD_W'(row9) * PROD_W'(grid_width) + PROD_W'(col9);
    chk_stop = chk_valid && (chk_out || ram_rdata);
  end

  always_comb begin
    mag_c_w = diff_c[C] ? -diff_c : diff_c;
    mag_r_w = diff_r[C] ? -diff_r : diff_r;
    mag_c   = mag_c_w[C-1:0];
    mag_r   = mag_r_w[C-1:0];
    sum_sq  = {1'b0, sq_c} + {1'b0, sq_r};
    rem_sh  = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial   = REM_W'({root, 2'b01});
  end

  assign ram_we    = cmd_acc && (func == grc_pkg::FUNC_LOAD);
  assign ram_waddr = ADDR_W'(cell_address);
  assign ram_raddr = ADDR_W'(lin);

  grc_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cell_blocked),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      grid_width  <= grc_pkg::GRID_DIM_RESET;
      grid_height <= grc_pkg::GRID_DIM_RESET;
      issue_live  <= 1'b0;
      chk_valid   <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          grc_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
          grc_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
        endcase
      end

      if (res_post) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_acc && (func == grc_pkg::FUNC_CAST)) begin
            c0    <= start_col;
            r0    <= start_row;
            c1    <= end_col;
            r1    <= end_row;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          steep      <= steep_s;
          a          <= steep_s ? r0 : c0;
          b          <= steep_s ? c0 : r0;
          a1         <= steep_s ? r1 : c1;
          a_up       <= steep_s ? (r1 > r0) : (c1 > c0);
          b_up       <= steep_s ? (c1 > c0) : (r1 > r0);
          da         <= steep_s ? arow : acol;
          db         <= steep_s ? acol : arow;
          err        <= '0;
          issue_live <= 1'b1;
          chk_valid  <= 1'b0;
          state      <= ST_WALK;
        end
        ST_WALK: begin
          if (chk_stop || (chk_valid && chk_last)) begin
            stop_blocked <= chk_stop;
            diff_c <= chk_stop ? {chk_col[C-1], chk_col} - {c0[C-1], c0} : dcol;
            diff_r <= chk_stop ? {chk_row[C-1], chk_row} - {r0[C-1], r0} : drow;
            chk_valid  <= 1'b0;
            issue_live <= 1'b0;
            state      <= ST_SQUARE;
          end else begin
            chk_valid <= issue_live;
            chk_out   <= cur_out;
            chk_last  <= cur_last;
            chk_col   <= cur_col;
            chk_row   <= cur_row;
            if (issue_live) begin
              a   <= a_next;
              err <= err_next;
              if (step_b) begin
                b <= b_next;
              end
              if (cur_last) begin
                issue_live <= 1'b0;
              end
            end
          end
        end
        ST_SQUARE: begin
          sq_c  <= mag_c * mag_c;
          sq_r  <= mag_r * mag_r;
          state <= ST_SUM;
        end
        ST_SUM: begin
          rad   <= {1'b0, sum_sq, {(2 * grc_pkg::FRAC_BITS){1'b0}}};
          rem   <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          rad <= {rad[RAD_W-3:0], 2'b00};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(ROOT_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_post) begin
            blocked      <= stop_blocked;
            hit_distance <= grc_pkg::DIST_W'(root);
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `GRC_ASSERT_IMPL(a_last_cell_held, (state == ST_WALK) && !issue_live, chk_valid, "walk lost its last cell")
  `GRC_ASSERT_NEXT(a_stop_leaves_walk, (state == ST_WALK) && chk_stop, state == ST_SQUARE, "walk did not stop at a blocking cell")
  `GRC_ASSERT_NEXT(a_end_leaves_walk, (state == ST_WALK) && chk_valid && chk_last, state == ST_SQUARE, "walk ran past the end cell")
  `GRC_ASSERT_NEXT(a_done_posts, (state == ST_DONE) && !res_valid, res_valid && (state == ST_IDLE), "result word not posted")

endmodule

/* sv/grc_ram.sv */
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* test/grid_ray_cast_top_tb.sv */
// Self-checking testbench for grid_ray_cast_top: loads occupancy cells, casts rays
// under several map sizes and handshake idling patterns, and checks each result word.
// Depends on grc_pkg and the grid_ray_cast_top RTL.
module grid_ray_cast_top_tb;

  localparam int COORD_W     = grc_pkg::COORD_BITS_DEFAULT;
  localparam int STORE_DEPTH = grc_pkg::GRID_SIDE_DEFAULT * grc_pkg::GRID_SIDE_DEFAULT;
  localparam int LIMIT       = 20000;
  localparam int HOLD_CYCLES = 800;
  localparam int COOL_CYCLES = 40;

  localparam int PHASES = 10;
  localparam int PH_COLS  [PHASES] = '{256, 16,  1,   1, 256,   0, 511,  37, 256, 200};
  localparam int PH_ROWS  [PHASES] = '{256, 16,  1, 256,   1, 200, 511, 300, 256,   0};
  localparam int PH_SEND  [PHASES] = '{  0, 78,  0,  29,   0,  78,   0,  29,   0,  78};
  localparam int PH_RECV  [PHASES] = '{  0,  0, 78,  29,   0,   0,  78,  29,   0,   0};
  localparam int PH_BLOCK [PHASES] = '{ 12, 20, 30,  15,  15,  15,  35,  15,  12,  15};
  localparam int PH_WORDS [PHASES] = '{ 90, 60, 30,  50,  50,  20,  70,  60, 100,  20};

  typedef struct {
    logic                               func_code;
    logic [grc_pkg::CELL_ADDR_W-1:0]    addr;
    logic                               occ;
    logic signed [COORD_W-1:0]          c0, r0, c1, r1;
  } grid_word_t;

  typedef struct packed {
    logic                       hit;
    logic [grc_pkg::DIST_W-1:0] distance;
  } ray_outcome_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [grc_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [grc_pkg::CFG_W-1:0]          cfg_data = '0;
  logic                               cmd_valid = 1'b0;
  logic                               cmd_ready;
  logic                               func = 1'b0;
  logic [grc_pkg::CELL_ADDR_W-1:0]    cell_address = '0;
  logic                               cell_blocked = 1'b0;
  logic signed [COORD_W-1:0]          start_col = '0;
  logic signed [COORD_W-1:0]          start_row = '0;
  logic signed [COORD_W-1:0]          end_col = '0;
  logic signed [COORD_W-1:0]          end_row = '0;
  logic                               res_valid;
  logic                               res_ready = 1'b0;
  logic                               blocked;
  logic [grc_pkg::DIST_W-1:0]         hit_distance;

  grid_word_t   cmd_words[$];
  ray_outcome_t ray_outcomes[$];
  bit           occ_now    [STORE_DEPTH];
  bit           occ_plan   [STORE_DEPTH];
  bit           plan_known [STORE_DEPTH];
  int           map_cols = int'(grc_pkg::GRID_DIM_RESET);
  int           map_rows = int'(grc_pkg::GRID_DIM_RESET);
  int           words_queued = 0;
  int           words_taken = 0;
  int           errors = 0;
  int           stall_run = 0;
  int           send_idle = 0;
  int           recv_stall = 0;
  int           block_pct = 12;
  int           hold_left = 0;
  logic         held = 1'b0;
  logic         pressure_arm = 1'b0;
  logic         cmd_fire = 1'b0;

  grid_ray_cast_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .func(func),
    .cell_address(cell_address), .cell_blocked(cell_blocked),
    .start_col(start_col), .start_row(start_row), .end_col(end_col), .end_row(end_row),
    .res_valid(res_valid), .res_ready(res_ready),
    .blocked(blocked), .hit_distance(hit_distance)
  );

  always #5 clk = ~clk;

  function automatic logic [grc_pkg::DIST_W-1:0] cell_dist(input int dc, input int dr);
    longint sq, root, trial;
    sq = (longint'(dc) * dc + longint'(dr) * dr) * 256;
    root = 0;
    for (int k = grc_pkg::DIST_W - 1; k >= 0; k--) begin
      trial = root | (longint'(1) << k);
      if (trial * trial <= sq) root = trial;
    end
    return root[grc_pkg::DIST_W-1:0];
  endfunction

  // plan=1 walks the planned store and stops at the first cell not yet loaded
  function automatic ray_outcome_t trace_ray(input int c0, r0, c1, r1, input bit plan,
                                             output int gap);
    int maj, mnr, maj_end, maj_step, mnr_step, d_maj, d_mnr, err, col, row, addr;
    bit steep, outside;
    ray_outcome_t res;
    gap = -1;
    addr = 0;
    d_maj = (c1 > c0) ? c1 - c0 : c0 - c1;
    d_mnr = (r1 > r0) ? r1 - r0 : r0 - r1;
    steep = d_maj < d_mnr;
    if (steep) begin
      maj = r0; mnr = c0; maj_end = r1;
      maj_step = (r1 > r0) ? 1 : -1;
      mnr_step = (c1 > c0) ? 1 : -1;
      {d_maj, d_mnr} = {d_mnr, d_maj};
    end else begin
      maj = c0; mnr = r0; maj_end = c1;
      maj_step = (c1 > c0) ? 1 : -1;
      mnr_step = (r1 > r0) ? 1 : -1;
    end
    err = 0;
    forever begin
      col = steep ? mnr : maj;
      row = steep ? maj : mnr;
      outside = col < 0 || row < 0 || col >= map_cols || row >= map_rows;
      if (!outside) begin
        addr = (row * map_cols + col) % STORE_DEPTH;
        if (plan && !plan_known[addr]) begin
          gap = addr;
          return res;
        end
      end
      if (outside || (plan ? occ_plan[addr] : occ_now[addr])) begin
        res.hit = 1'b1;
        res.distance = cell_dist(col - c0, row - r0);
        return res;
      end
      if (maj == maj_end) break;
      maj += maj_step;
      err += d_mnr;
      if (2 * err >= d_maj) begin
        mnr += mnr_step;
        err -= d_maj;
      end
    end
    res.hit = 1'b0;
    res.distance = cell_dist(c1 - c0, r1 - r0);
    return res;
  endfunction

  function automatic void push_load(input int addr, input bit occ);
    grid_word_t w;
    w.func_code = grc_pkg::FUNC_LOAD;
    w.addr = addr[grc_pkg::CELL_ADDR_W-1:0];
    w.occ = occ;
    w.c0 = COORD_W'($urandom);
    w.r0 = COORD_W'($urandom);
    w.c1 = COORD_W'($urandom);
    w.r1 = COORD_W'($urandom);
    occ_plan[w.addr] = occ;
    plan_known[w.addr] = 1'b1;
    cmd_words.insert(cmd_words.size(), w);
    words_queued++;
  endfunction

  // loads every cell the ray would read before the cast word itself
  function automatic void plan_cast(input int c0, r0, c1, r1);
    grid_word_t w;
    ray_outcome_t unused;
    int gap;
    do begin
      unused = trace_ray(c0, r0, c1, r1, 1'b1, gap);
      if (gap >= 0) push_load(gap, $urandom_range(99) < block_pct);
    end while (gap >= 0);
    w.func_code = grc_pkg::FUNC_CAST;
    w.addr = grc_pkg::CELL_ADDR_W'($urandom);
    w.occ = 1'($urandom);
    w.c0 = c0[COORD_W-1:0];
    w.r0 = r0[COORD_W-1:0];
    w.c1 = c1[COORD_W-1:0];
    w.r1 = r1[COORD_W-1:0];
    cmd_words.insert(cmd_words.size(), w);
    words_queued++;
  endfunction

  function automatic int clip_coord(input int v);
    return (v < -1024) ? -1024 : (v > 1023) ? 1023 : v;
  endfunction

  function automatic int near_coord(input int extent);
    return int'($urandom_range(0, extent + 3)) - 2;
  endfunction

  task automatic write_reg(input logic [grc_pkg::CFG_INDEX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[grc_pkg::CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk); while (words_taken != words_queued || ray_outcomes.size() != 0);
    repeat (COOL_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin
    grid_word_t w;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_fire) begin
      if (cmd_words.size() != 0 && $urandom_range(99) >= send_idle) begin
        w = cmd_words.pop_front();
        func <= w.func_code;
        cell_address <= w.addr;
        cell_blocked <= w.occ;
        start_col <= w.c0;
        start_row <= w.r0;
        end_col <= w.c1;
        end_row <= w.r1;
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      hold_left <= 0;
      held <= 1'b0;
    end else if (pressure_arm && !held) begin
      res_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      held <= 1'b1;
    end else if (hold_left != 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      res_ready <= $urandom_range(99) >= recv_stall;
    end
  end

  always @(posedge clk) begin : watch
    ray_outcome_t want;
    int gap;
    if (rst) begin
      cmd_fire <= 1'b0;
      map_cols = int'(grc_pkg::GRID_DIM_RESET);
      map_rows = int'(grc_pkg::GRID_DIM_RESET);
      stall_run = 0;
    end else begin
      cmd_fire <= cmd_valid && cmd_ready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == grc_pkg::REG_GRID_WIDTH) map_cols = int'(cfg_data);
        else map_rows = int'(cfg_data);
      end
      if (res_valid && res_ready) begin
        if (ray_outcomes.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, blocked=%0b hit_distance=%0d",
                   $time, blocked, hit_distance);
        end else begin
          want = ray_outcomes.pop_front();
          if (blocked !== want.hit) begin
            errors++;
            $display("%0t: blocked expected %0b, got %0b", $time, want.hit, blocked);
          end
          if (hit_distance !== want.distance) begin
            errors++;
            $display("%0t: hit_distance expected %0d, got %0d",
                     $time, want.distance, hit_distance);
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        words_taken++;
        if (func == grc_pkg::FUNC_LOAD) occ_now[cell_address] = cell_blocked;
        else ray_outcomes.insert(ray_outcomes.size(),
                                 trace_ray(int'(start_col), int'(start_row), int'(end_col),
                                           int'(end_row), 1'b0, gap));
      end
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
        stall_run = 0;
      else
        stall_run++;
      if (stall_run >= LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int c0, r0, c1, r1, reach, phase_end;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_load(0, 1'b0);
    push_load(STORE_DEPTH - 1, 1'b1);
    plan_cast(0, 0, 0, 0);
    plan_cast(255, 255, 200, 250);
    plan_cast(-1024, -1024, 1023, 1023);
    plan_cast(1023, 1023, -1024, -1024);
    plan_cast(0, 0, -7, 0);
    plan_cast(3, 1, 4, -4);
    plan_cast(252, 10, 258, 11);
    plan_cast(10, 253, 11, 259);
    plan_cast(20, 20, 23, 23);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(grc_pkg::REG_GRID_WIDTH, PH_COLS[p]);
      write_reg(grc_pkg::REG_GRID_HEIGHT, PH_ROWS[p]);
      @(posedge clk);
      send_idle = PH_SEND[p];
      recv_stall = PH_RECV[p];
      block_pct = PH_BLOCK[p];
      phase_end = words_queued + PH_WORDS[p];
      while (words_queued < phase_end) begin
        if ($urandom_range(99) < 8) begin
          push_load($urandom_range(0, STORE_DEPTH - 1), 1'($urandom_range(0, 1)));
        end else if ($urandom_range(99) < 10) begin
          plan_cast(int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024,
                    int'($urandom_range(0, 2047)) - 1024, int'($urandom_range(0, 2047)) - 1024);
        end else begin
          c0 = near_coord(map_cols);
          r0 = near_coord(map_rows);
          reach = ($urandom_range(99) < 6) ? 1023 : 24;
          c1 = clip_coord(c0 + int'($urandom_range(0, 2 * reach)) - reach);
          r1 = clip_coord(r0 + int'($urandom_range(0, 2 * reach)) - reach);
          plan_cast(c0, r0, c1, r1);
        end
      end
      if (p == 0) pressure_arm = 1'b1;
    end
    drain();

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
